// File: design/sefr_pkg.sv
`default_nettype none

package sefr_pkg;

    localparam int GAP_W  = 24;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 12;
    localparam int KIND_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W  = 24;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEST_CODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GET_ID_CODE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESEND_CODE = 2'd3;

    localparam logic [GAP_W-1:0]  GAP_TICKS_RST   = 24'd1000000;
    localparam logic [BYTE_W-1:0] TEST_CODE_RST   = 8'd1;
    localparam logic [BYTE_W-1:0] GET_ID_CODE_RST = 8'd2;
    localparam logic [BYTE_W-1:0] RESEND_CODE_RST = 8'd3;

    localparam logic [GAP_W-1:0] GAP_MAX = {GAP_W{1'b1}};

    // result kinds
    localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FRAME_OK = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TRANSMIT = 2'd3;

    localparam logic [BYTE_W-1:0] CHR_S = 8'h53;
    localparam logic [BYTE_W-1:0] CHR_T = 8'h54;
    localparam logic [BYTE_W-1:0] CHR_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHR_E = 8'h45;
    localparam logic [BYTE_W-1:0] CHR_N = 8'h4E;
    localparam logic [BYTE_W-1:0] CHR_D = 8'h44;

    localparam logic [3:0] RESEND_LEN = 4'd7;

    typedef struct packed {
        logic [GAP_W-1:0]  gap_ticks;
        logic [BYTE_W-1:0] test_code;
        logic [BYTE_W-1:0] get_id_code;
        logic [BYTE_W-1:0] resend_code;
    } cfg_t;

    // what follows the optional payload byte of one request
    typedef enum logic [1:0] {
        POST_NONE,
        POST_ACCEPT,
        POST_OK,
        POST_RESEND
    } post_t;

    typedef struct packed {
        logic              has_byte;
        logic [BYTE_W-1:0] data;
        post_t             post;
        logic [BYTE_W-1:0] cmd;
        logic [LEN_W-1:0]  len;
    } desc_t;

    // header or trailer byte at a chunk position
    function automatic logic [BYTE_W-1:0] chunk_byte(input logic trailer,
                                                     input logic [1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            2'd0:    b = trailer ? CHR_E : CHR_S;
            2'd1:    b = trailer ? CHR_N : CHR_T;
            default: b = trailer ? CHR_D : CHR_A;
        endcase
        return b;
    endfunction

    // byte of the resend frame at a position
    function automatic logic [BYTE_W-1:0] resend_byte(input logic [2:0] pos,
                                                      input logic [BYTE_W-1:0] code);
        logic [BYTE_W-1:0] b;
        case (pos)
            3'd0:    b = CHR_S;
            3'd1:    b = CHR_T;
            3'd2:    b = CHR_A;
            3'd3:    b = code;
            3'd4:    b = CHR_E;
            3'd5:    b = CHR_N;
            default: b = CHR_D;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: design/sefr_cfg_regs.sv
`default_nettype none

module sefr_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          we,
    input  wire logic [sefr_pkg::CFG_IDX_W-1:0] index,
    input  wire logic [sefr_pkg::CFG_W-1:0]     data,
    output sefr_pkg::cfg_t                     cfg
);
    import sefr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap_ticks   <= GAP_TICKS_RST;
            cfg_reg.test_code   <= TEST_CODE_RST;
            cfg_reg.get_id_code <= GET_ID_CODE_RST;
            cfg_reg.resend_code <= RESEND_CODE_RST;
        end
        else if (we)
        begin
            case (index)
                REG_GAP_TICKS:   cfg_reg.gap_ticks   <= data[GAP_W-1:0];
                REG_TEST_CODE:   cfg_reg.test_code   <= data[BYTE_W-1:0];
                REG_GET_ID_CODE: cfg_reg.get_id_code <= data[BYTE_W-1:0];
                REG_RESEND_CODE: cfg_reg.resend_code <= data[BYTE_W-1:0];
                default:         cfg_reg.resend_code <= data[BYTE_W-1:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: design/sefr_frame_fsm.sv
`default_nettype none

module sefr_frame_fsm (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        take,
    input  wire logic                        command,
    input  wire logic [sefr_pkg::BYTE_W-1:0] rx_byte,
    input  wire sefr_pkg::cfg_t              cfg,
    output sefr_pkg::desc_t                  desc,
    output logic                             has_result
);
    import sefr_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_COUNT,
        PH_PAYLOAD,
        PH_TRAILER
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [1:0]        chunk_count_reg, chunk_count_next;
    logic              chunk_match_reg, chunk_match_next;
    logic [BYTE_W-1:0] frame_cmd_reg, frame_cmd_next;
    logic [LEN_W-1:0]  payload_length_reg, payload_length_next;
    logic [LEN_W-1:0]  payload_count_reg, payload_count_next;
    logic [GAP_W-1:0]  gap_count_reg, gap_count_next;

    logic [GAP_W-1:0]  gap_inc;
    logic [1:0]        idx;
    logic [1:0]        idx_inc;
    logic [LEN_W-1:0]  len_new;
    logic [LEN_W-1:0]  count_inc;
    logic              cmd_known;
    desc_t             d;

    always_comb
    begin
        phase_next          = phase_reg;
        chunk_count_next    = chunk_count_reg;
        chunk_match_next    = chunk_match_reg;
        frame_cmd_next      = frame_cmd_reg;
        payload_length_next = payload_length_reg;
        payload_count_next  = payload_count_reg;
        gap_count_next      = gap_count_reg;
        d                   = '0;
        d.post              = POST_NONE;

        gap_inc   = (gap_count_reg != GAP_MAX) ? gap_count_reg + 1'b1 : gap_count_reg;
        idx       = (chunk_count_reg > 2'd2) ? 2'd2 : chunk_count_reg;
        idx_inc   = idx + 1'b1;
        len_new   = (frame_cmd_reg == cfg.get_id_code)
                  ? {4'b0, rx_byte} + {1'b0, rx_byte, 3'b0}
                  : {4'b0, rx_byte};
        count_inc = payload_count_reg + 1'b1;
        cmd_known = (frame_cmd_reg == cfg.test_code) || (frame_cmd_reg == cfg.get_id_code);

        if (command)
        begin
            if (gap_inc >= cfg.gap_ticks)
            begin
                gap_count_next   = '0;
                chunk_count_next = '0;
                chunk_match_next = 1'b1;
                if (phase_reg != PH_HEADER)
                begin
                    d.post     = POST_RESEND;
                    phase_next = PH_HEADER;
                end
            end
            else
            begin
                gap_count_next = gap_inc;
            end
        end
        else
        begin
            gap_count_next = '0;
            case (phase_reg)
                PH_HEADER, PH_TRAILER:
                begin
                    chunk_count_next = idx_inc;
                    if (rx_byte != chunk_byte(phase_reg == PH_TRAILER, idx))
                        chunk_match_next = 1'b0;
                    if (idx_inc == 2'd3)
                    begin
                        chunk_count_next = '0;
                        chunk_match_next = 1'b1;
                        // match flag must include the byte just checked
                        if (phase_reg == PH_HEADER)
                        begin
                            if (chunk_match_reg && rx_byte == chunk_byte(1'b0, idx))
                                phase_next = PH_COUNT;
                        end
                        else if (chunk_match_reg && rx_byte == chunk_byte(1'b1, idx))
                        begin
                            phase_next = PH_HEADER;
                            d.post     = POST_OK;
                        end
                        else
                        begin
                            phase_next = PH_HEADER;
                            d.post     = POST_RESEND;
                        end
                    end
                end
                PH_COUNT:
                begin
                    if (chunk_count_reg == 2'd0)
                    begin
                        frame_cmd_next   = rx_byte;
                        chunk_count_next = 2'd1;
                    end
                    else
                    begin
                        payload_length_next = len_new;
                        payload_count_next  = '0;
                        chunk_count_next    = '0;
                        phase_next          = PH_PAYLOAD;
                        if (len_new == '0)
                        begin
                            chunk_match_next = 1'b1;
                            if (cmd_known)
                            begin
                                d.post     = POST_ACCEPT;
                                phase_next = PH_TRAILER;
                            end
                            else
                            begin
                                d.post     = POST_RESEND;
                                phase_next = PH_HEADER;
                            end
                        end
                    end
                end
                default:
                begin
                    d.has_byte         = 1'b1;
                    d.data             = rx_byte;
                    payload_count_next = count_inc;
                    if (count_inc >= payload_length_reg)
                    begin
                        chunk_count_next = '0;
                        chunk_match_next = 1'b1;
                        if (cmd_known)
                        begin
                            d.post     = POST_ACCEPT;
                            phase_next = PH_TRAILER;
                        end
                        else
                        begin
                            d.post     = POST_RESEND;
                            phase_next = PH_HEADER;
                        end
                    end
                end
            endcase
        end

        d.cmd = frame_cmd_next;
        d.len = payload_length_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HEADER;
            chunk_count_reg    <= '0;
            chunk_match_reg    <= 1'b1;
            frame_cmd_reg      <= '0;
            payload_length_reg <= '0;
            payload_count_reg  <= '0;
            gap_count_reg      <= '0;
        end
        else if (take)
        begin
            phase_reg          <= phase_next;
            chunk_count_reg    <= chunk_count_next;
            chunk_match_reg    <= chunk_match_next;
            frame_cmd_reg      <= frame_cmd_next;
            payload_length_reg <= payload_length_next;
            payload_count_reg  <= payload_count_next;
            gap_count_reg      <= gap_count_next;
        end
    end

    assign desc       = d;
    assign has_result = d.has_byte || (d.post != POST_NONE);

endmodule

`default_nettype wire

// File: design/sefr_emitter.sv
`default_nettype none

module sefr_emitter (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire sefr_pkg::desc_t             desc_in,
    input  wire logic [sefr_pkg::BYTE_W-1:0] resend_code,
    output logic                             busy,
    output logic                             finishing,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [sefr_pkg::KIND_W-1:0]      kind,
    output logic [sefr_pkg::BYTE_W-1:0]      out_byte,
    output logic [sefr_pkg::BYTE_W-1:0]      frame_command,
    output logic [sefr_pkg::LEN_W-1:0]       frame_length,
    output logic                             last
);
    import sefr_pkg::*;

    desc_t      desc_reg;
    logic       valid_reg;
    logic [2:0] idx_reg;

    logic [3:0] total;
    logic [2:0] pos;
    logic       on_byte;
    logic       take_out;

    always_comb
    begin
        case (desc_reg.post)
            POST_NONE:   total = {3'b0, desc_reg.has_byte};
            POST_RESEND: total = RESEND_LEN + {3'b0, desc_reg.has_byte};
            default:     total = 4'd1 + {3'b0, desc_reg.has_byte};
        endcase
        on_byte = desc_reg.has_byte && (idx_reg == 3'd0);
        pos     = idx_reg - {2'b0, desc_reg.has_byte};
        last    = ({1'b0, idx_reg} + 4'd1) == total;

        if (on_byte)
        begin
            kind     = KIND_PAYLOAD;
            out_byte = desc_reg.data;
        end
        else
        begin
            case (desc_reg.post)
                POST_ACCEPT:
                begin
                    kind     = KIND_ACCEPTED;
                    out_byte = '0;
                end
                POST_OK:
                begin
                    kind     = KIND_FRAME_OK;
                    out_byte = '0;
                end
                default:
                begin
                    kind     = KIND_TRANSMIT;
                    out_byte = resend_byte(pos, resend_code);
                end
            endcase
        end
    end

    assign frame_command = desc_reg.cmd;
    assign frame_length  = desc_reg.len;
    assign out_valid     = valid_reg;
    assign take_out      = valid_reg && out_ready;
    assign finishing     = take_out && last;
    assign busy          = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (finishing)
        begin
            valid_reg <= 1'b0;
        end
        else if (take_out)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            desc_reg <= '0;
        else if (load)
            desc_reg <= desc_in;
    end

endmodule

`default_nettype wire

// File: design/sta_end_frame_receiver.sv
// latency: a request's first result is shown in the cycle after it is accepted
// throughput: one request per cycle while no result is pending; results hold the
// input until the last leaves; they leave the result register one per cycle while
// out_ready is high (up to eight: a payload byte and the seven-byte resend frame)
// reset: asynchronous, active low; state, registers and output valid clear at once
`default_nettype none

module sta_end_frame_receiver (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [sefr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sefr_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           command,
    input  wire logic [sefr_pkg::BYTE_W-1:0]    rx_byte,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [sefr_pkg::KIND_W-1:0]         kind,
    output logic [sefr_pkg::BYTE_W-1:0]         out_byte,
    output logic [sefr_pkg::BYTE_W-1:0]         frame_command,
    output logic [sefr_pkg::LEN_W-1:0]          frame_length,
    output logic                                last
);
    import sefr_pkg::*;

    cfg_t  cfg;
    desc_t desc;
    logic  has_result;
    logic  busy;
    logic  finishing;
    logic  take;

    sefr_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    assign in_ready = !busy || finishing;
    assign take     = in_valid && in_ready;

    sefr_frame_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .command    (command),
        .rx_byte    (rx_byte),
        .cfg        (cfg),
        .desc       (desc),
        .has_result (has_result)
    );

    sefr_emitter u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (take && has_result),
        .desc_in       (desc),
        .resend_code   (cfg.resend_code),
        .busy          (busy),
        .finishing     (finishing),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .out_byte      (out_byte),
        .frame_command (frame_command),
        .frame_length  (frame_length),
        .last          (last)
    );

    // input is held off only while results are still pending
    a_ready_only_when_draining: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no pending result");

    // a new request may only overlap the final result of the previous one
    a_overlap_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && out_valid) |-> (last && out_ready))
        else $error("request accepted while results still queued");

    // a multi-result burst continues without a gap
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> out_valid)
        else $error("result burst broken before last");

endmodule

`default_nettype wire

// File: tb/sefr_checker.sv
`timescale 1ns / 1ps

module sefr_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [sefr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sefr_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           in_valid,
    input  wire logic                           in_ready,
    input  wire logic                           command,
    input  wire logic [sefr_pkg::BYTE_W-1:0]    rx_byte,
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire logic [sefr_pkg::KIND_W-1:0]    kind,
    input  wire logic [sefr_pkg::BYTE_W-1:0]    out_byte,
    input  wire logic [sefr_pkg::BYTE_W-1:0]    frame_command,
    input  wire logic [sefr_pkg::LEN_W-1:0]     frame_length,
    input  wire logic                           last,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  requests_seen,
    output int                                  results_seen,
    output int                                  frames_ok,
    output int                                  resend_frames
);
    import sefr_pkg::*;

    localparam logic [3*BYTE_W-1:0] HEADER_SEQ  = {CHR_S, CHR_T, CHR_A};
    localparam logic [3*BYTE_W-1:0] TRAILER_SEQ = {CHR_E, CHR_N, CHR_D};

    typedef enum logic [1:0] {
        HUNT_HEADER,
        TAKE_CMD_COUNT,
        TAKE_PAYLOAD,
        CHECK_TRAILER
    } rx_phase_t;

    typedef struct packed {
        logic [KIND_W-1:0] res_kind;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] cmd;
        logic [LEN_W-1:0]  len;
        logic              is_last;
    } frame_result_t;

    frame_result_t     awaited_results[$];

    cfg_t              regs;
    rx_phase_t         rx_phase;
    logic [1:0]        chunk_pos;
    logic              chunk_good;
    logic [BYTE_W-1:0] cur_cmd;
    logic [LEN_W-1:0]  cur_len;
    logic [LEN_W-1:0]  rcvd;
    logic [GAP_W-1:0]  gap_run;

    int fails;
    int n_requests;
    int n_results;
    int n_frames_ok;
    int n_resends;

    task automatic note(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] d);
        frame_result_t r;
        r.res_kind = k;
        r.data     = d;
        r.cmd      = cur_cmd;
        r.len      = cur_len;
        r.is_last  = 1'b0;
        awaited_results.push_back(r);
    endtask

    task automatic note_resend();
        note(KIND_TRANSMIT, CHR_S);
        note(KIND_TRANSMIT, CHR_T);
        note(KIND_TRANSMIT, CHR_A);
        note(KIND_TRANSMIT, regs.resend_code);
        note(KIND_TRANSMIT, CHR_E);
        note(KIND_TRANSMIT, CHR_N);
        note(KIND_TRANSMIT, CHR_D);
        n_resends++;
        rx_phase   = HUNT_HEADER;
        chunk_pos  = 2'd0;
        chunk_good = 1'b1;
    endtask

    task automatic close_payload();
        if (cur_cmd == regs.test_code || cur_cmd == regs.get_id_code)
        begin
            note(KIND_ACCEPTED, '0);
            rx_phase   = CHECK_TRAILER;
            chunk_pos  = 2'd0;
            chunk_good = 1'b1;
        end
        else
        begin
            note_resend();
        end
    endtask

    // works out every result that one request causes
    task automatic predict(input logic tick, input logic [BYTE_W-1:0] b);
        int                queued_at_start;
        frame_result_t     tail;
        logic [BYTE_W-1:0] want;
        logic              ok;
        queued_at_start = awaited_results.size();
        if (tick)
        begin
            if (gap_run != GAP_MAX)
                gap_run = gap_run + 1'b1;
            if (gap_run >= regs.gap_ticks)
            begin
                gap_run = '0;
                if (rx_phase == HUNT_HEADER)
                begin
                    chunk_pos  = 2'd0;
                    chunk_good = 1'b1;
                end
                else
                begin
                    note_resend();
                end
            end
        end
        else
        begin
            gap_run = '0;
            case (rx_phase)
                HUNT_HEADER, CHECK_TRAILER:
                begin
                    want = (rx_phase == CHECK_TRAILER) ?
                           TRAILER_SEQ[3*BYTE_W-1 - BYTE_W*chunk_pos -: BYTE_W] :
                           HEADER_SEQ[3*BYTE_W-1 - BYTE_W*chunk_pos -: BYTE_W];
                    if (b != want)
                        chunk_good = 1'b0;
                    chunk_pos = chunk_pos + 2'd1;
                    if (chunk_pos == 2'd3)
                    begin
                        ok         = chunk_good;
                        chunk_pos  = 2'd0;
                        chunk_good = 1'b1;
                        if (rx_phase == HUNT_HEADER)
                        begin
                            if (ok)
                                rx_phase = TAKE_CMD_COUNT;
                        end
                        else if (ok)
                        begin
                            rx_phase = HUNT_HEADER;
                            note(KIND_FRAME_OK, '0);
                            n_frames_ok++;
                        end
                        else
                        begin
                            note_resend();
                        end
                    end
                end
                TAKE_CMD_COUNT:
                begin
                    if (chunk_pos == 2'd0)
                    begin
                        cur_cmd   = b;
                        chunk_pos = 2'd1;
                    end
                    else
                    begin
                        cur_len = (cur_cmd == regs.get_id_code) ?
                                  {4'd0, b} * 12'd9 : {4'd0, b};
                        rcvd      = '0;
                        chunk_pos = 2'd0;
                        rx_phase  = TAKE_PAYLOAD;
                        // a zero count completes the payload on the count byte
                        if (cur_len == '0)
                            close_payload();
                    end
                end
                default:
                begin
                    note(KIND_PAYLOAD, b);
                    rcvd = rcvd + 1'b1;
                    if (rcvd >= cur_len)
                        close_payload();
                end
            endcase
        end
        if (awaited_results.size() > queued_at_start)
        begin
            tail = awaited_results.pop_back();
            tail.is_last = 1'b1;
            awaited_results.push_back(tail);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t want;
        if (!rst_n)
        begin
            regs.gap_ticks   = GAP_TICKS_RST;
            regs.test_code   = TEST_CODE_RST;
            regs.get_id_code = GET_ID_CODE_RST;
            regs.resend_code = RESEND_CODE_RST;
            rx_phase    = HUNT_HEADER;
            chunk_pos   = 2'd0;
            chunk_good  = 1'b1;
            cur_cmd     = '0;
            cur_len     = '0;
            rcvd        = '0;
            gap_run     = '0;
            awaited_results.delete();
            fails       = 0;
            n_requests  = 0;
            n_results   = 0;
            n_frames_ok = 0;
            n_resends   = 0;
            fail_count    <= 0;
            pending       <= 0;
            requests_seen <= 0;
            results_seen  <= 0;
            frames_ok     <= 0;
            resend_frames <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAP_TICKS:   regs.gap_ticks   = cfg_data;
                    REG_TEST_CODE:   regs.test_code   = cfg_data[BYTE_W-1:0];
                    REG_GET_ID_CODE: regs.get_id_code = cfg_data[BYTE_W-1:0];
                    default:         regs.resend_code = cfg_data[BYTE_W-1:0];
                endcase
            end
            // results leaving now belong to requests taken at earlier edges
            if (out_valid && out_ready)
            begin
                n_results++;
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result with nothing awaited, kind %0d byte %0d",
                             $time, kind, out_byte);
                    fails++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("kind", want.res_kind, kind);
                    check_field("out_byte", want.data, out_byte);
                    check_field("frame_command", want.cmd, frame_command);
                    check_field("frame_length", want.len, frame_length);
                    check_field("last", want.is_last, last);
                end
            end
            if (in_valid && in_ready)
            begin
                n_requests++;
                predict(command, rx_byte);
            end
            fail_count    <= fails;
            pending       <= awaited_results.size();
            requests_seen <= n_requests;
            results_seen  <= n_results;
            frames_ok     <= n_frames_ok;
            resend_frames <= n_resends;
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import sefr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [3*BYTE_W-1:0] HEADER_SEQ  = {CHR_S, CHR_T, CHR_A};
    localparam logic [3*BYTE_W-1:0] TRAILER_SEQ = {CHR_E, CHR_N, CHR_D};

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 command   = 1'b0;
    logic [BYTE_W-1:0]    rx_byte   = '0;
    logic                 out_ready = 1'b0;
    logic                 in_ready;
    logic                 out_valid;
    logic [KIND_W-1:0]    kind;
    logic [BYTE_W-1:0]    out_byte;
    logic [BYTE_W-1:0]    frame_command;
    logic [LEN_W-1:0]     frame_length;
    logic                 last;

    int fail_count;
    int pending;
    int requests_seen;
    int results_seen;
    int frames_ok;
    int resend_frames;

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int stalled_cycles    = 0;
    int requests_sent     = 0;
    int gap_now;
    logic [BYTE_W-1:0] test_now;
    logic [BYTE_W-1:0] get_id_now;

    sta_end_frame_receiver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .out_byte      (out_byte),
        .frame_command (frame_command),
        .frame_length  (frame_length),
        .last          (last)
    );

    sefr_checker frame_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .out_byte      (out_byte),
        .frame_command (frame_command),
        .frame_length  (frame_length),
        .last          (last),
        .fail_count    (fail_count),
        .pending       (pending),
        .requests_seen (requests_seen),
        .results_seen  (results_seen),
        .frames_ok     (frames_ok),
        .resend_frames (resend_frames)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= receiver_idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    initial
    begin
        wait (stalled_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb failed");
        $finish;
    end

    task automatic push_request(input logic tick, input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= tick;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        requests_sent++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        push_request(1'b0, b);
    endtask

    task automatic send_ticks(input int n);
        repeat (n)
            push_request(1'b1, BYTE_W'($urandom));
    endtask

    // short silences that stay under the gap limit
    task automatic jitter();
        if (gap_now >= 2 && $urandom_range(9) == 0)
            send_ticks($urandom_range(1, (gap_now > 6) ? 5 : gap_now - 1));
    endtask

    // three-byte chunk, with one byte spoilt where spoil is below three
    task automatic send_chunk(input logic [3*BYTE_W-1:0] seq, input int spoil);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i < 3; i++)
        begin
            b = seq[3*BYTE_W-1 - BYTE_W*i -: BYTE_W];
            if (i == spoil)
                b = b ^ BYTE_W'($urandom_range(1, 255));
            jitter();
            send_byte(b);
        end
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] count,
                              input logic bad_trailer);
        int len;
        len = (cmd == get_id_now) ? int'(count) * 9 : int'(count);
        send_chunk(HEADER_SEQ, 3);
        jitter();
        send_byte(cmd);
        jitter();
        send_byte(count);
        repeat (len)
        begin
            jitter();
            send_byte(BYTE_W'($urandom));
        end
        send_chunk(TRAILER_SEQ, bad_trailer ? $urandom_range(2) : 3);
    endtask

    // hold the sender until every awaited result is out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic configure(input int gap, input logic [BYTE_W-1:0] test,
                             input logic [BYTE_W-1:0] get_id, input logic [BYTE_W-1:0] resend);
        write_reg(REG_GAP_TICKS, CFG_W'(gap));
        write_reg(REG_TEST_CODE, {16'($urandom), test});
        write_reg(REG_GET_ID_CODE, {16'($urandom), get_id});
        write_reg(REG_RESEND_CODE, {16'($urandom), resend});
        cfg_we     <= 1'b0;
        gap_now    = gap;
        test_now   = test;
        get_id_now = get_id;
    endtask

    task automatic random_traffic();
        int                pick;
        int                count;
        logic [BYTE_W-1:0] cmd;
        pick = $urandom_range(99);
        cmd  = $urandom_range(1) ? test_now : get_id_now;
        if (pick < 65)
        begin
            if (cmd == get_id_now)
                count = $urandom_range(2);
            else if ($urandom_range(49) == 0)
                count = $urandom_range(200, 255);
            else
                count = $urandom_range(6);
            send_frame(cmd, BYTE_W'(count), $urandom_range(9) == 0);
        end
        else if (pick < 75)
        begin
            send_frame(BYTE_W'($urandom), BYTE_W'($urandom_range(3)), 1'b0);
        end
        else if (pick < 85)
        begin
            // line goes quiet part way into a frame
            send_chunk(HEADER_SEQ, 3);
            send_byte(cmd);
            if ($urandom_range(1))
            begin
                count = $urandom_range(1, 4);
                send_byte(BYTE_W'(count));
                repeat ($urandom_range(count - 1))
                    send_byte(BYTE_W'($urandom));
            end
            send_ticks(gap_now);
        end
        else if (pick < 93)
        begin
            send_chunk(HEADER_SEQ, $urandom_range(2));
        end
        else
        begin
            // line noise, then enough silence to realign the header hunt
            repeat ($urandom_range(1, 5))
                send_byte(BYTE_W'($urandom));
            send_ticks(gap_now);
        end
    endtask

    task automatic random_phase(input int snd_idle, input int rcv_idle, input int quota,
                                input int gap_lo, input int gap_hi);
        int   start;
        logic paused;
        drain();
        sender_idle_pct   = snd_idle;
        receiver_idle_pct <= rcv_idle;
        configure($urandom_range(gap_lo, gap_hi), BYTE_W'($urandom), BYTE_W'($urandom),
                  BYTE_W'($urandom));
        start  = requests_sent;
        paused = 1'b0;
        while (requests_sent - start < quota)
        begin
            random_traffic();
            if (!paused && requests_sent - start >= quota / 2)
            begin
                drain();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        sender_idle_pct   = 8;
        receiver_idle_pct <= 81;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extreme codes, zero resend code
        configure(2, 8'h00, 8'hFF, 8'h00);
        // one payload byte, then a spoilt trailer
        send_chunk(HEADER_SEQ, 3);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_chunk(TRAILER_SEQ, 2);
        // partial header dropped on a gap timeout
        send_byte(CHR_S);
        send_ticks(2);
        // empty get-id payload, good trailer
        send_chunk(HEADER_SEQ, 3);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_chunk(TRAILER_SEQ, 3);
        // unknown command with empty payload is rejected on the count byte
        send_chunk(HEADER_SEQ, 3);
        send_byte(8'h7E);
        send_byte(8'h00);
        // gap timeout straight after the header
        send_chunk(HEADER_SEQ, 3);
        send_ticks(2);

        // zero gap limit: every tick times out
        drain();
        configure(0, 8'h00, 8'hFF, 8'h00);
        send_ticks(1);
        send_chunk(HEADER_SEQ, 3);
        send_ticks(1);

        // widest gap limit, codes swapped to the other extremes
        drain();
        configure(int'(GAP_MAX), 8'hFF, 8'h00, 8'hFF);
        send_chunk(HEADER_SEQ, 3);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_ticks(3);
        send_byte(8'h5A);
        send_chunk(TRAILER_SEQ, 3);
        send_frame(8'h00, 8'h01, 1'b0);

        drain();
        configure(1, 8'h10, 8'h20, 8'h01);
        send_chunk(HEADER_SEQ, 3);
        send_byte(8'h20);
        send_ticks(1);

        random_phase(8, 81, 110, 2, 6);
        random_phase(81, 8, 110, 3, 10);
        random_phase(0, 0, 110, 2, 8);
        // longest payload length the count allows, cut short by a gap timeout
        send_chunk(HEADER_SEQ, 3);
        send_byte(get_id_now);
        send_byte(8'hFF);
        repeat (3)
            send_byte(BYTE_W'($urandom));
        send_ticks(gap_now);

        drain();
        repeat (8) @(posedge clk);
        $display("covered %0d requests: directed frames, gap and code extremes, three mixes",
                 requests_seen);
        $display("%0d results checked, %0d frames closed ok, %0d resend frames",
                 results_seen, frames_ok, resend_frames);
        if (fail_count == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// File: sta_end_frame_receiver.f
design/sefr_pkg.sv
design/sefr_cfg_regs.sv
design/sefr_frame_fsm.sv
design/sefr_emitter.sv
design/sta_end_frame_receiver.sv
tb/sefr_checker.sv
tb/tb.sv
